// ===== hdl/pidtc_pkg.sv =====
// pidtc_pkg: shared widths, types and register codes of the pid temperature controller
`default_nettype none

package pidtc_pkg;

	localparam int CHANNELS = 4;
	localparam int CH_W     = 2;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int TEMP_W  = 16;
	localparam int ERR_W   = 17;
	localparam int DIFF_W  = 18;
	localparam int ACC_W   = 32;
	localparam int GAIN_W  = 24;
	localparam int LIM_W   = 15;
	localparam int BOUND_W = 31;
	localparam int PROD_W  = GAIN_W + 1 + ACC_W;
	localparam int RAW_W   = PROD_W + 1;
	localparam int FRAC_SH = 12;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	localparam logic [GAIN_W-1:0]  KP_RST    = GAIN_W'(216269);
	localparam logic [GAIN_W-1:0]  KI_RST    = GAIN_W'(131);
	localparam logic [GAIN_W-1:0]  KD_RST    = GAIN_W'(0);
	localparam logic [LIM_W-1:0]   UPPER_RST = LIM_W'(25600);
	localparam logic [LIM_W-1:0]   LOWER_RST = LIM_W'(0);
	localparam logic [BOUND_W-1:0] BOUND_RST = BOUND_W'(800000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP    = 3'd0,
		REG_KI    = 3'd1,
		REG_KD    = 3'd2,
		REG_UPPER = 3'd3,
		REG_LOWER = 3'd4,
		REG_BOUND = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_P,
		PH_I,
		PH_D
	} phase_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
	} gains_t;

	typedef struct packed {
		logic signed [ERR_W-1:0]  e;
		logic signed [ACC_W-1:0]  sum;
		logic signed [DIFF_W-1:0] diff;
		logic                     ok;
	} op_t;

	typedef struct packed {
		logic signed [RAW_W-1:0] raw;
		logic                    ok;
	} res_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] acc;
		logic signed [ERR_W-1:0] prev;
	} ent_t;

endpackage

`default_nettype wire

// ===== hdl/pidtc_if.sv =====
// pidtc_if: sample, drive and configuration channel interfaces
`default_nettype none

interface pidtc_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [pidtc_pkg::CH_W-1:0]            channel;
	logic signed [pidtc_pkg::TEMP_W-1:0]   measured;
	logic signed [pidtc_pkg::TEMP_W-1:0]   target;

	modport source (output valid, output channel, output measured, output target, input ready);
	modport sink   (input valid, input channel, input measured, input target, output ready);
endinterface

interface pidtc_out_if;
	logic                             valid;
	logic                             ready;
	logic [pidtc_pkg::LIM_W-1:0]      drive;
	logic                             clamped;

	modport source (output valid, output drive, output clamped, input ready);
	modport sink   (input valid, input drive, input clamped, output ready);
endinterface

interface pidtc_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [pidtc_pkg::CFG_IDX_W-1:0]     index;
	logic [pidtc_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/pid_temperature_controller_unit.sv =====
// pid_temperature_controller_unit: multi-channel fixed-point pid with anti-windup
//
//  port    dir   beat contents                  accepted when
//  cfg     in    index, data                    cfg.valid & cfg.ready (ready always 1)
//  samp    in    channel, measured, target      samp.valid & samp.ready
//  drv     out   drive, clamped                 drv.valid & drv.ready
//
// one 25x32 multiplier forms kp, ki and kd terms in turn; next sample enters as kd issues
// sample path: s1 register, mac operand, product and result registers, drive register
// per-channel state sits in a small ram with registered read; a back-to-back update of the
// same channel is forwarded from the write port
// reset clears the ram valid bits at once, so no clearing pass is needed
// a stalled drive beat holds in its register while the next sample is still taken in
`default_nettype none

module pid_temperature_controller_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	pidtc_cfg_if.sink  cfg,
	pidtc_in_if.sink   samp,
	pidtc_out_if.source drv
);
	import pidtc_pkg::*;

	// configuration registers
	logic [GAIN_W-1:0]  kp_q;
	logic [GAIN_W-1:0]  ki_q;
	logic [GAIN_W-1:0]  kd_q;
	logic [LIM_W-1:0]   upper_q;
	logic [LIM_W-1:0]   lower_q;
	logic [BOUND_W-1:0] bound_q;
	gains_t             gains;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= KP_RST;
			ki_q    <= KI_RST;
			kd_q    <= KD_RST;
			upper_q <= UPPER_RST;
			lower_q <= LOWER_RST;
			bound_q <= BOUND_RST;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_KP:    kp_q    <= cfg.data[GAIN_W-1:0];
				REG_KI:    ki_q    <= cfg.data[GAIN_W-1:0];
				REG_KD:    kd_q    <= cfg.data[GAIN_W-1:0];
				REG_UPPER: upper_q <= cfg.data[LIM_W-1:0];
				REG_LOWER: lower_q <= cfg.data[LIM_W-1:0];
				REG_BOUND: bound_q <= cfg.data[BOUND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign gains.kp = kp_q;
	assign gains.ki = ki_q;
	assign gains.kd = kd_q;

	// channel state ram and valid bits
	ent_t               mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;

	logic                     v_s1;
	logic [CH_W-1:0]          ch_s1;
	logic signed [TEMP_W-1:0] meas_s1;
	logic signed [TEMP_W-1:0] targ_s1;
	ent_t                     rd_s1;
	logic                     vld_s1;
	logic                     fwd_s1;
	ent_t                     fwd_ent_s1;

	logic samp_beat;
	logic s1_move;
	logic op_ready;
	logic ok_s1;
	logic [CH_IDX_W-1:0] idx_in;
	logic [CH_IDX_W-1:0] idx_s1;

	ent_t                     old_ent;
	ent_t                     new_ent;
	logic signed [ERR_W-1:0]  e_s1;
	logic signed [ACC_W:0]    sum_raw;
	logic signed [ACC_W:0]    bnd;
	logic signed [ACC_W:0]    sum_clip;
	logic signed [DIFF_W-1:0] diff_s1;
	op_t                      op;

	assign samp.ready = !v_s1 || op_ready;
	assign samp_beat  = samp.valid && samp.ready;
	assign s1_move    = v_s1 && op_ready;
	assign ok_s1      = int'(ch_s1) < CHANNELS;
	assign idx_in     = CH_IDX_W'(samp.channel);
	assign idx_s1     = CH_IDX_W'(ch_s1);

	always_comb begin
		if (fwd_s1) begin
			old_ent = fwd_ent_s1;
		end else if (vld_s1) begin
			old_ent = rd_s1;
		end else begin
			old_ent = '0;
		end
		e_s1    = ERR_W'(targ_s1) - ERR_W'(meas_s1);
		sum_raw = (ACC_W + 1)'(old_ent.acc) + (ACC_W + 1)'(e_s1);
		bnd     = signed'({2'b00, bound_q});
		// symmetric anti-windup clamp
		if (sum_raw > bnd) begin
			sum_clip = bnd;
		end else if (sum_raw < -bnd) begin
			sum_clip = -bnd;
		end else begin
			sum_clip = sum_raw;
		end
		diff_s1      = DIFF_W'(e_s1) - DIFF_W'(old_ent.prev);
		new_ent.acc  = sum_clip[ACC_W-1:0];
		new_ent.prev = e_s1;
		op.e         = e_s1;
		op.sum       = new_ent.acc;
		op.diff      = diff_s1;
		op.ok        = ok_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			vld_q <= '0;
		end else begin
			if (samp_beat) begin
				v_s1 <= 1'b1;
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
			if (s1_move && ok_s1) begin
				vld_q[idx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samp_beat) begin
			rd_s1      <= mem[idx_in];
			vld_s1     <= vld_q[idx_in];
			// the ram returns the old entry when the write lands in the same cycle
			fwd_s1     <= s1_move && ok_s1 && (ch_s1 == samp.channel);
			fwd_ent_s1 <= new_ent;
			ch_s1      <= samp.channel;
			meas_s1    <= samp.measured;
			targ_s1    <= samp.target;
		end
		if (s1_move && ok_s1) begin
			mem[idx_s1] <= new_ent;
		end
	end

	// term multiply and sum
	res_t res;
	logic res_valid;
	logic res_ready;

	pidtc_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.gains     (gains),
		.op_valid  (s1_move),
		.op        (op),
		.op_ready  (op_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// output limit, rounding and drive register
	logic                    out_v_q;
	logic [LIM_W-1:0]        drive_q;
	logic                    clamped_q;
	logic signed [RAW_W-1:0] hi_w;
	logic signed [RAW_W-1:0] lo_w;
	logic signed [RAW_W-1:0] rnd;
	logic                    above;
	logic                    below;
	logic [LIM_W-1:0]        drive_nxt;
	logic                    clamped_nxt;

	assign res_ready = !out_v_q || drv.ready;

	always_comb begin
		hi_w  = RAW_W'({upper_q, {FRAC_SH{1'b0}}});
		lo_w  = RAW_W'({lower_q, {FRAC_SH{1'b0}}});
		rnd   = res.raw + RAW_W'(2048);
		above = res.raw > hi_w;
		// once clipped to the upper limit, the lower limit still wins if it is higher
		below = above ? (upper_q < lower_q) : (res.raw < lo_w);
		if (!res.ok) begin
			drive_nxt   = lower_q;
			clamped_nxt = 1'b0;
		end else if (below) begin
			drive_nxt   = lower_q;
			clamped_nxt = 1'b1;
		end else if (above) begin
			drive_nxt   = upper_q;
			clamped_nxt = 1'b1;
		end else begin
			drive_nxt   = rnd[FRAC_SH+LIM_W-1:FRAC_SH];
			clamped_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_ready) begin
			out_v_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			drive_q   <= drive_nxt;
			clamped_q <= clamped_nxt;
		end
	end

	assign drv.valid   = out_v_q;
	assign drv.drive   = drive_q;
	assign drv.clamped = clamped_q;

endmodule

`default_nettype wire

// ===== hdl/pidtc_mac.sv =====
// pidtc_mac: shared multiplier stepping through the three pid terms and summing them
`default_nettype none

module pidtc_mac (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pidtc_pkg::gains_t gains,
	input  wire logic              op_valid,
	input  wire pidtc_pkg::op_t    op,
	output logic                   op_ready,
	output logic                   res_valid,
	output pidtc_pkg::res_t        res,
	input  wire logic              res_ready
);
	import pidtc_pkg::*;

	op_t    op_s2;
	logic   v_s2;
	phase_t phase_q;
	phase_t phase_nxt;

	logic signed [PROD_W-1:0] prod_s3;
	logic                     v_s3;
	logic                     first_s3;
	logic                     last_s3;
	logic                     ok_s3;

	logic signed [RAW_W-1:0] acc_q;
	logic signed [RAW_W-1:0] acc_nxt;
	res_t                    res_q;
	logic                    res_v_q;

	logic signed [GAIN_W:0]  mul_a;
	logic signed [ACC_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;

	logic res_free;
	logic consume;
	logic adv;
	logic issue;
	logic op_take;

	assign res_free = !res_v_q || res_ready;
	assign consume  = v_s3 && (!last_s3 || res_free);
	assign adv      = !v_s3 || consume;
	assign issue    = v_s2 && adv;
	assign op_ready = !v_s2 || (issue && (phase_q == PH_D));
	assign op_take  = op_valid && op_ready;

	// operand select for the current term
	always_comb begin
		case (phase_q)
			PH_P: begin
				mul_a = signed'({1'b0, gains.kp});
				mul_b = ACC_W'(op_s2.e);
			end
			PH_I: begin
				mul_a = signed'({1'b0, gains.ki});
				mul_b = op_s2.sum;
			end
			PH_D: begin
				mul_a = signed'({1'b0, gains.kd});
				mul_b = ACC_W'(op_s2.diff);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		case (phase_q)
			PH_P:    phase_nxt = PH_I;
			PH_I:    phase_nxt = PH_D;
			PH_D:    phase_nxt = PH_P;
			default: phase_nxt = PH_P;
		endcase
	end

	assign acc_nxt = first_s3 ? RAW_W'(prod_s3) : acc_q + RAW_W'(prod_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			phase_q <= PH_P;
			v_s3    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (op_take) begin
				v_s2 <= 1'b1;
			end else if (issue && (phase_q == PH_D)) begin
				v_s2 <= 1'b0;
			end
			if (issue) begin
				phase_q <= phase_nxt;
			end
			if (adv) begin
				v_s3 <= issue;
			end
			if (consume && last_s3) begin
				res_v_q <= 1'b1;
			end else if (res_ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_take) begin
			op_s2 <= op;
		end
		if (issue) begin
			prod_s3  <= mul_p;
			first_s3 <= (phase_q == PH_P);
			last_s3  <= (phase_q == PH_D);
			ok_s3    <= op_s2.ok;
		end
		if (consume) begin
			acc_q <= acc_nxt;
			if (last_s3) begin
				res_q.raw <= acc_nxt;
				res_q.ok  <= ok_s3;
			end
		end
	end

	assign res_valid = res_v_q;
	assign res       = res_q;

endmodule

`default_nettype wire
